@@ src/rdst_pkg.sv @@
// ----------------------------------------------------------------------------
// rdst_pkg
// Shared types and constants for the RAM disk slot table.
// ----------------------------------------------------------------------------
package rdst_pkg;

    localparam int WORD_W = 64;   // device ids and sector words
    localparam int SIZE_W = 8;    // sector counts and sector indexes

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_READ    = 2'd2,
        CMD_WRITE   = 2'd3
    } t_cmd;

    // Result of the parallel slot search
    typedef struct packed {
        logic              hit;        // an active slot holds the id
        logic              free_avail; // some slot is inactive
        logic [SIZE_W-1:0] hit_size;   // size of the lowest matching slot
    } t_lookup;

    // Slot table update request
    typedef struct packed {
        logic claim;
        logic free;
    } t_slot_upd;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] read_value;
        logic [WORD_W-1:0] new_id;
        logic [SIZE_W-1:0] sectors;
    } t_result;

endpackage

@@ src/rdst_ram.sv @@
// ----------------------------------------------------------------------------
// rdst_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rdst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rdst_slots.sv @@
// ----------------------------------------------------------------------------
// rdst_slots
// Slot descriptors (active, id, size) with parallel id match and free search.
// ----------------------------------------------------------------------------
module rdst_slots #(
    parameter int SLOTS  = 8,
    parameter int SLOT_W = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rdst_pkg::WORD_W-1:0] i_id,
    input  rdst_pkg::t_slot_upd        i_upd,
    input  logic [SLOT_W-1:0]          i_upd_slot,
    input  logic [rdst_pkg::WORD_W-1:0] i_new_id,
    input  logic [rdst_pkg::SIZE_W-1:0] i_new_size,
    output rdst_pkg::t_lookup          o_lookup,
    output logic [SLOT_W-1:0]          o_hit_slot,
    output logic [SLOT_W-1:0]          o_free_slot
);

    logic [SLOTS-1:0]                r_active;
    logic [rdst_pkg::WORD_W-1:0]     r_ids   [SLOTS];
    logic [rdst_pkg::SIZE_W-1:0]     r_sizes [SLOTS];
    logic [SLOTS-1:0]                hit_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (i_upd.claim) begin
                r_active[i_upd_slot] <= 1'b1;
            end
            if (i_upd.free) begin
                r_active[i_upd_slot] <= 1'b0;
            end
        end
    end

    // ids and sizes are only looked at while the slot is active
    always_ff @(posedge i_clk) begin
        if (i_upd.claim) begin
            r_ids[i_upd_slot]   <= i_new_id;
            r_sizes[i_upd_slot] <= i_new_size;
        end
    end

    // lowest index wins for both searches
    always_comb begin
        o_hit_slot  = '0;
        o_free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            hit_vec[i] = r_active[i] && (r_ids[i] == i_id);
            if (hit_vec[i]) begin
                o_hit_slot = SLOT_W'(i);
            end
            if (!r_active[i]) begin
                o_free_slot = SLOT_W'(i);
            end
        end
        o_lookup.hit        = |hit_vec;
        o_lookup.free_avail = ~&r_active;
        o_lookup.hit_size   = r_sizes[o_hit_slot];
    end

endmodule

@@ src/ram_disk_slot_table.sv @@
// ----------------------------------------------------------------------------
// ram_disk_slot_table
// Table of small RAM disks: create, destroy, read and write sector requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream (tuser = command, tdata = id, sector,
//   write word, sector count). Each request gives exactly one result on the
//   master stream (tuser = status, tdata = read word, new id, device size).
//   The slot descriptors sit in flip-flops and are searched in parallel; the
//   sector words live in one single-port RAM addressed by {slot, sector}.
//   Requests are handled one at a time; the RAM port sets the pace.
//   Every request passes a lookup step and an output step; a read adds
//   one RAM read step, and a create adds a slot clear with one RAM write
//   per sector.
//   A new request is taken in the cycle after the previous result is loaded.
//   A result waits in the output register while the receiver stalls; a
//   request already taken then holds in its last step until the register
//   frees up.
//   Reset empties the table and zeroes the id counter. The sector RAM is not
//   swept: a device's sectors are cleared when it is created, and no other
//   sector can be read.
// ----------------------------------------------------------------------------
module ram_disk_slot_table #(
    parameter int SLOTS   = 8,
    parameter int SECTORS = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [63:0] device_id, [71:64] sector, [135:72] write_value,
    // [143:136] sector_count
    input  logic [143:0] i_s_tdata,
    // [1:0] command
    input  logic [1:0]   i_s_tuser,
    // master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [63:0] read_value, [127:64] new_device_id, [135:128] device_sectors
    output logic [135:0] o_m_tdata,
    // [0] status
    output logic [0:0]   o_m_tuser
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEC_W  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int ADDR_W = SLOT_W + SEC_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WW     = rdst_pkg::WORD_W;
    localparam int SW     = rdst_pkg::SIZE_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_READ  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    rdst_pkg::t_cmd      r_cmd, n_cmd;
    logic [WW-1:0]       r_id, n_id;
    logic [SW-1:0]       r_sec, n_sec;
    logic [WW-1:0]       r_wval, n_wval;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SEC_W-1:0]    r_clr, n_clr;
    logic [WW-1:0]       r_idc, n_idc;
    rdst_pkg::t_result   r_res, n_res;
    logic                r_m_valid, n_m_valid;
    rdst_pkg::t_result   r_m_res, n_m_res;

    rdst_pkg::t_lookup   lookup;
    rdst_pkg::t_slot_upd upd;
    logic [SLOT_W-1:0]   hit_slot;
    logic [SLOT_W-1:0]   free_slot;
    logic [SLOT_W-1:0]   upd_slot;
    logic [WW-1:0]       idc_inc;
    logic                cnt_ok;
    logic [SEC_W-1:0]    clr_last;
    logic [SW-1:0]       cnt_m1;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WW-1:0]       ram_wdata;
    logic [WW-1:0]       ram_rdata;

    rdst_slots #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_id        (r_id),
        .i_upd       (upd),
        .i_upd_slot  (upd_slot),
        .i_new_id    (idc_inc),
        .i_new_size  (r_cnt),
        .o_lookup    (lookup),
        .o_hit_slot  (hit_slot),
        .o_free_slot (free_slot)
    );

    rdst_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign idc_inc  = r_idc + 64'd1;
    assign cnt_ok   = (r_cnt != '0) && (r_cnt <= SW'(SECTORS));
    assign cnt_m1   = r_cnt - 8'd1;
    assign clr_last = cnt_m1[SEC_W-1:0];

    // One request in flight at a time, so RAM read/write never overlap.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_sec     = r_sec;
        n_wval    = r_wval;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_clr     = r_clr;
        n_idc     = r_idc;
        n_res     = r_res;
        n_m_res   = r_m_res;
        n_m_valid = r_m_valid & ~i_m_tready;
        upd       = '0;
        upd_slot  = free_slot;
        ram_we    = 1'b0;
        ram_addr  = {hit_slot, r_sec[SEC_W-1:0]};
        ram_wdata = r_wval;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd         = rdst_pkg::t_cmd'(i_s_tuser);
                    n_id          = i_s_tdata[63:0];
                    n_sec         = i_s_tdata[71:64];
                    n_wval        = i_s_tdata[135:72];
                    n_cnt         = i_s_tdata[143:136];
                    n_res         = '0;
                    n_res.status  = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_OUT;
                case (r_cmd)
                    rdst_pkg::CMD_CREATE: begin
                        if (cnt_ok && lookup.free_avail) begin
                            upd.claim     = 1'b1;
                            n_idc         = idc_inc;
                            n_slot        = free_slot;
                            n_clr         = '0;
                            n_res.status  = 1'b0;
                            n_res.new_id  = idc_inc;
                            n_res.sectors = r_cnt;
                            n_state       = S_CLEAR;
                        end
                    end
                    rdst_pkg::CMD_DESTROY: begin
                        if (lookup.hit) begin
                            upd.free      = 1'b1;
                            upd_slot      = hit_slot;
                            n_res.status  = 1'b0;
                            n_res.sectors = lookup.hit_size;
                        end
                    end
                    rdst_pkg::CMD_READ, rdst_pkg::CMD_WRITE: begin
                        // size never exceeds SECTORS, so the sector fits SEC_W bits
                        if (lookup.hit && (r_sec < lookup.hit_size)) begin
                            n_res.status  = 1'b0;
                            n_res.sectors = lookup.hit_size;
                            if (r_cmd == rdst_pkg::CMD_WRITE) begin
                                ram_we = 1'b1;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_READ: begin
                n_res.read_value = ram_rdata;
                n_state          = S_OUT;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = {r_slot, r_clr};
                ram_wdata = '0;
                n_clr     = r_clr + SEC_W'(1);
                if (r_clr == clr_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_res   = r_res;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idc     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idc     <= n_idc;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_id    <= n_id;
        r_sec   <= n_sec;
        r_wval  <= n_wval;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        r_clr   <= n_clr;
        r_res   <= n_res;
        r_m_res <= n_m_res;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_res.sectors, r_m_res.new_id, r_m_res.read_value};
    assign o_m_tuser  = r_m_res.status;

    // clear sweep stays inside the new device
    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> ({{(SW - SEC_W){1'b0}}, r_clr} < r_cnt))
        else $error("clear sweep past device size");

    // RAM is written only by a write request or by the create clear
    a_ram_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) ||
                    ((r_state == S_LOOK) && (r_cmd == rdst_pkg::CMD_WRITE))))
        else $error("unexpected sector write");

    // id counter moves only while a create is decided
    a_idc_create_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_LOOK) && (r_cmd == rdst_pkg::CMD_CREATE)) |=> $stable(r_idc))
        else $error("id counter changed outside create");

    // every successful result names a device of nonzero size
    a_ok_has_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == 1'b0)) |-> (o_m_tdata[135:128] != '0))
        else $error("success result without device size");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ram_disk_slot_table. A mirror of the slot table,
// id counter and sector words predicts one reply per accepted request. Replies
// are checked in order, field by field. Requests start with a directed run
// of error cases and table extremes. Random traffic follows, mostly aimed at
// live devices. Both streams idle at random, with one long stretch without
// gaps.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS   = 8;
    localparam int SECTORS = 128;
    localparam int N_RANDOM = 1000;
    localparam int WORD_W  = rdst_pkg::WORD_W;
    localparam int SIZE_W  = rdst_pkg::SIZE_W;

    typedef struct {
        rdst_pkg::t_cmd    cmd;
        logic [WORD_W-1:0] dev_id;
        logic [SIZE_W-1:0] sector;
        logic [WORD_W-1:0] wval;
        logic [SIZE_W-1:0] count;
    } t_disk_req;

    // Mirror of the slot table; predicts each reply when its request is taken
    class slot_table_mirror;
        logic              active [SLOTS];
        logic [WORD_W-1:0] ids    [SLOTS];
        logic [SIZE_W-1:0] sizes  [SLOTS];
        logic [WORD_W-1:0] words  [SLOTS*SECTORS];
        logic [WORD_W-1:0] id_counter;
        rdst_pkg::t_result pending_replies [$];
        int                mismatches;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                active[s] = 1'b0;
                ids[s]    = '0;
                sizes[s]  = '0;
            end
            for (int a = 0; a < SLOTS*SECTORS; a++) begin
                words[a] = '0;
            end
            id_counter = '0;
            mismatches = 0;
        endfunction

        function int find_device(logic [WORD_W-1:0] id);
            for (int s = 0; s < SLOTS; s++) begin
                if (active[s] && ids[s] == id) return s;
            end
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int s = 0; s < SLOTS; s++) begin
                if (active[s]) n++;
            end
            return n;
        endfunction

        function void note_request(t_disk_req rq);
            rdst_pkg::t_result r;
            int                s;
            r = '0;
            r.status = 1'b1;
            if (rq.cmd == rdst_pkg::CMD_CREATE) begin
                if (rq.count >= 1 && rq.count <= SECTORS) begin
                    s = -1;
                    for (int k = SLOTS - 1; k >= 0; k--) begin
                        if (!active[k]) s = k;
                    end
                    if (s >= 0) begin
                        id_counter = id_counter + WORD_W'(1);
                        active[s] = 1'b1;
                        ids[s]    = id_counter;
                        sizes[s]  = rq.count;
                        for (int a = 0; a < SECTORS; a++) words[s*SECTORS + a] = '0;
                        r.status  = 1'b0;
                        r.new_id  = id_counter;
                        r.sectors = rq.count;
                    end
                end
            end else begin
                s = find_device(rq.dev_id);
                if (s >= 0) begin
                    if (rq.cmd == rdst_pkg::CMD_DESTROY) begin
                        r.sectors = sizes[s];
                        r.status  = 1'b0;
                        active[s] = 1'b0;
                        ids[s]    = '0;
                    end else if (rq.sector < sizes[s] && rq.sector < SECTORS) begin
                        if (rq.cmd == rdst_pkg::CMD_READ)
                            r.read_value = words[s*SECTORS + rq.sector];
                        else
                            words[s*SECTORS + rq.sector] = rq.wval;
                        r.sectors = sizes[s];
                        r.status  = 1'b0;
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("%0t: MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(rdst_pkg::t_result got);
            rdst_pkg::t_result want;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", got.new_id, '0);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.new_id !== want.new_id)
                    report_mismatch("new_device_id", got.new_id, want.new_id);
                if (got.sectors !== want.sectors)
                    report_mismatch("device_sectors", WORD_W'(got.sectors),
                                    WORD_W'(want.sectors));
            end
        endtask
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [143:0]   s_tdata = '0;    // [63:0] id, [71:64] sector, [135:72] word, [143:136] count
    logic [1:0]     s_tuser = '0;    // [1:0] command
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [135:0]   m_tdata;         // [63:0] read word, [127:64] new id, [135:128] size
    logic [0:0]     m_tuser;         // [0] status
    logic           idle_on = 1'b1;

    slot_table_mirror table_mirror = new();

    ram_disk_slot_table #(
        .SLOTS   (SLOTS),
        .SECTORS (SECTORS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 20);
    end

    always @(posedge i_clk) begin
        rdst_pkg::t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status     = m_tuser[0];
            got.read_value = m_tdata[63:0];
            got.new_id     = m_tdata[127:64];
            got.sectors    = m_tdata[135:128];
            table_mirror.check_result(got);
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic t_disk_req make_req(rdst_pkg::t_cmd cmd, logic [WORD_W-1:0] id,
                                           logic [SIZE_W-1:0] sec, logic [WORD_W-1:0] wval,
                                           logic [SIZE_W-1:0] cnt);
        t_disk_req rq;
        rq.cmd    = cmd;
        rq.dev_id = id;
        rq.sector = sec;
        rq.wval   = wval;
        rq.count  = cnt;
        return rq;
    endfunction

    // Mostly well-formed traffic on live devices, with some noise
    function automatic t_disk_req random_request();
        t_disk_req rq;
        int        n_live;
        int        roll;
        int        slot;
        rq.dev_id = {$urandom, $urandom};
        rq.sector = SIZE_W'($urandom_range(255));
        rq.wval   = rand_word();
        rq.count  = SIZE_W'($urandom_range(255));
        n_live = table_mirror.live_count();
        roll = $urandom_range(99);
        if ((n_live == 0 && roll < 85) || (n_live < SLOTS && roll < 25) || roll < 3)
            rq.cmd = rdst_pkg::CMD_CREATE;
        else if (roll < 40 || (n_live == SLOTS && roll < 50))
            rq.cmd = rdst_pkg::CMD_DESTROY;
        else if (roll < 70)
            rq.cmd = rdst_pkg::CMD_READ;
        else
            rq.cmd = rdst_pkg::CMD_WRITE;

        if (rq.cmd == rdst_pkg::CMD_CREATE) begin
            if ($urandom_range(99) < 85) begin
                roll = $urandom_range(19);
                if (roll == 0)
                    rq.count = SIZE_W'(SECTORS);
                else if (roll < 3)
                    rq.count = SIZE_W'($urandom_range(SECTORS, 1));
                else
                    rq.count = SIZE_W'($urandom_range(8, 1));
            end
        end else if (n_live > 0 && $urandom_range(99) < 88) begin
            slot = $urandom_range(SLOTS - 1);
            while (!table_mirror.active[slot]) slot = (slot + 1) % SLOTS;
            rq.dev_id = table_mirror.ids[slot];
            if ($urandom_range(99) < 85)
                rq.sector = SIZE_W'($urandom_range(table_mirror.sizes[slot] - 1));
        end else if ($urandom_range(1) == 0) begin
            // ids near the counter: live, freed or not yet issued
            rq.dev_id = table_mirror.id_counter + WORD_W'(1) - WORD_W'($urandom_range(3));
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task send_request(t_disk_req rq);
        if (idle_on) begin
            while ($urandom_range(99) < 20) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.count, rq.wval, rq.sector, rq.dev_id};
        s_tuser  <= rq.cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        table_mirror.note_request(rq);
        @(negedge i_clk);
    endtask

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing is live after reset, not even id zero
        send_request(make_req(rdst_pkg::CMD_READ,    '0, 8'd0, '1, 8'd1));
        send_request(make_req(rdst_pkg::CMD_DESTROY, '0, 8'd0, '0, 8'd1));
        send_request(make_req(rdst_pkg::CMD_WRITE,   '0, 8'd0, '1, 8'd1));
        // bad create counts
        send_request(make_req(rdst_pkg::CMD_CREATE, '1, 8'd0,   '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_CREATE, '0, 8'd0,   '0, SIZE_W'(SECTORS + 1)));
        send_request(make_req(rdst_pkg::CMD_CREATE, '0, 8'd255, '0, 8'd255));
        // smallest and largest device
        send_request(make_req(rdst_pkg::CMD_CREATE, '1, 8'd0, '0, 8'd1));
        send_request(make_req(rdst_pkg::CMD_CREATE, '0, 8'd0, '1, SIZE_W'(SECTORS)));
        send_request(make_req(rdst_pkg::CMD_WRITE, 64'd1, 8'd0, '1, 8'd0));
        send_request(make_req(rdst_pkg::CMD_READ,  64'd1, 8'd0, '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_READ,  64'd1, 8'd1, '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_WRITE, 64'd2, SIZE_W'(SECTORS - 1),
                              64'h0123_4567_89ab_cdef, 8'd0));
        send_request(make_req(rdst_pkg::CMD_READ,  64'd2, SIZE_W'(SECTORS - 1), '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_READ,  64'd2, SIZE_W'(SECTORS), '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_WRITE, 64'd2, 8'd255, '1, 8'd0));
        // fill the table, then one create too many
        for (int k = 0; k < SLOTS - 2; k++)
            send_request(make_req(rdst_pkg::CMD_CREATE, '0, 8'd0, '0, 8'd2));
        send_request(make_req(rdst_pkg::CMD_CREATE, '0, 8'd0, '0, 8'd5));
        // freed id no longer matches; reused slot comes back cleared
        send_request(make_req(rdst_pkg::CMD_DESTROY, 64'd1, 8'd0, '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_READ,    64'd1, 8'd0, '0, 8'd0));
        send_request(make_req(rdst_pkg::CMD_CREATE,  '0, 8'd0, '0, 8'd3));
        send_request(make_req(rdst_pkg::CMD_READ,    WORD_W'(SLOTS + 1), 8'd0, '0, 8'd0));

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = !(n >= 300 && n < 550);
            send_request(random_request());
        end
        idle_on = 1'b1;
        s_tvalid <= 1'b0;

        while (table_mirror.pending_replies.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (table_mirror.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rdst_pkg.sv
src/rdst_ram.sv
src/rdst_slots.sv
src/ram_disk_slot_table.sv
bench/tb.sv
